// File: rtl/dod_pkg.sv
// shared types, sizes and helpers for the delta-of-delta varint encoder
// no dependencies
`default_nettype none

package dod_pkg;

  localparam int BLOCK_RECORDS = 4;
  localparam int OFFSET_BITS   = 48;
  localparam int RIB_W         = (BLOCK_RECORDS > 2) ? $clog2(BLOCK_RECORDS) : 1;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic               command;
    logic [63:0]        timestamp;
    logic signed [31:0] price;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               last;
    logic               index_valid;
    logic [47:0]        index_offset;
    logic [63:0]        index_ts;
    logic signed [31:0] index_price;
  } out_word_t;

  // one input word's work as handed to the byte emitter
  typedef struct packed {
    logic        is_finish;
    logic        first;
    logic        close;
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] idx_ts;
    logic [31:0] idx_price;
  } job_t;

  function automatic logic [63:0] zigzag32(input logic [31:0] d);
    logic [31:0] z;
    z = {d[30:0], 1'b0} ^ {32{d[31]}};
    return {32'd0, z};
  endfunction

endpackage

`default_nettype wire

// File: rtl/dod_front.sv
// record state and delta computation, builds one job per accepted word
// depends on dod_pkg
`default_nettype none

module dod_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire dod_pkg::in_word_t in_data,
  output dod_pkg::job_t        job
);

  logic [31:0]              last_ts_lo;
  logic [31:0]              last_price;
  logic [31:0]              last_ts_delta;
  logic [dod_pkg::RIB_W-1:0] record_in_block;
  logic [63:0]              block_base_ts;
  logic [31:0]              block_base_price;

  logic        first;
  logic        close;
  logic [31:0] td;
  logic [31:0] dod;
  logic [31:0] pd;

  assign first = (record_in_block == '0);
  assign close = (record_in_block == dod_pkg::RIB_W'(dod_pkg::BLOCK_RECORDS - 1));
  assign td    = in_data.timestamp[31:0] - last_ts_lo;
  assign dod   = td - last_ts_delta;
  assign pd    = 32'(in_data.price) - last_price;

  always_comb begin
    job.is_finish = (in_data.command == dod_pkg::CMD_FINISH);
    job.first     = first && !job.is_finish;
    job.idx_ts    = block_base_ts;
    job.idx_price = block_base_price;
    if (job.is_finish) begin
      job.close = !first;
      job.v0    = '0;
      job.v1    = '0;
    end else if (first) begin
      job.close = 1'b0;
      job.v0    = in_data.timestamp;
      job.v1    = {{32{in_data.price[31]}}, 32'(in_data.price)};
    end else begin
      job.close = close;
      job.v0    = (record_in_block == dod_pkg::RIB_W'(1)) ? dod_pkg::zigzag32(td)
                                                          : dod_pkg::zigzag32(dod);
      job.v1    = dod_pkg::zigzag32(pd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ts_lo       <= '0;
      last_price       <= '0;
      last_ts_delta    <= '0;
      record_in_block  <= '0;
      block_base_ts    <= '0;
      block_base_price <= '0;
    end else if (accept) begin
      if (in_data.command == dod_pkg::CMD_FINISH) begin
        last_ts_lo       <= '0;
        last_price       <= '0;
        last_ts_delta    <= '0;
        record_in_block  <= '0;
        block_base_ts    <= '0;
        block_base_price <= '0;
      end else begin
        last_ts_lo <= in_data.timestamp[31:0];
        last_price <= 32'(in_data.price);
        if (first) begin
          last_ts_delta    <= '0;
          block_base_ts    <= in_data.timestamp;
          block_base_price <= 32'(in_data.price);
        end else begin
          last_ts_delta <= td;
        end
        record_in_block <= close ? '0 : record_in_block + dod_pkg::RIB_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/dod_emit.sv
// varint byte emitter: holds one job, shifts out 7-bit groups, tracks stream offset
// depends on dod_pkg
`default_nettype none

module dod_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire dod_pkg::job_t     job_in,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dod_pkg::out_word_t     out_data
);

  dod_pkg::job_t                job;
  logic                         job_valid;
  logic                         phase;
  logic                         at_start;
  logic [63:0]                  cur;
  logic [dod_pkg::OFFSET_BITS-1:0] byte_offset;
  logic [dod_pkg::OFFSET_BITS-1:0] block_start_offset;

  logic               step;
  logic               cont;
  logic               last_byte;
  logic [63:0]        start_wide;
  dod_pkg::out_word_t out_next;

  assign step      = job_valid && (!out_valid || out_ready);
  assign cont      = |cur[63:7];
  assign last_byte = job.is_finish || (phase && !cont);
  assign in_ready  = !job_valid || (step && last_byte);
  assign start_wide = 64'(block_start_offset);

  always_comb begin
    out_next.out_byte    = job.is_finish ? 8'd0 : {cont, cur[6:0]};
    out_next.byte_valid  = !job.is_finish;
    out_next.last        = last_byte;
    out_next.index_valid = last_byte && job.close;
    if (out_next.index_valid) begin
      out_next.index_offset = start_wide[47:0];
      out_next.index_ts     = job.idx_ts;
      out_next.index_price  = job.idx_price;
    end else begin
      out_next.index_offset = '0;
      out_next.index_ts     = '0;
      out_next.index_price  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid          <= 1'b0;
      out_valid          <= 1'b0;
      byte_offset        <= '0;
      block_start_offset <= '0;
      phase              <= 1'b0;
      at_start           <= 1'b0;
    end else begin
      if (step) begin
        out_data  <= out_next;
        out_valid <= 1'b1;
        if (job.is_finish) begin
          byte_offset        <= '0;
          block_start_offset <= '0;
        end else begin
          byte_offset <= byte_offset + dod_pkg::OFFSET_BITS'(1);
          if (at_start && job.first) begin
            block_start_offset <= byte_offset;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        job       <= job_in;
        cur       <= job_in.v0;
        phase     <= 1'b0;
        at_start  <= 1'b1;
        job_valid <= 1'b1;
      end else if (step) begin
        at_start <= 1'b0;
        if (!last_byte) begin
          if (!phase && !cont) begin
            phase <= 1'b1;
            cur   <= job.v1;
          end else begin
            cur <= {7'd0, cur[63:7]};
          end
        end else begin
          job_valid <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/delta_of_delta_varint_encoder_core.sv
// top level of the delta-of-delta varint encoder
// depends on dod_pkg, dod_front, dod_emit
//
// in channel (in_valid / in_ready / in_data) takes one word per record or a
// finish command; out channel (out_valid / out_ready / out_data) gives one word
// per stream byte, with last set on the final word of each input word.
// a block's first record produces 2 to 20 varint bytes, a later record 2 to 10;
// a finish command produces a single word that carries no byte.
// the emitter puts out one byte per cycle while the receiver does not stall it.
// a new input word is accepted in the cycle its predecessor's last byte moves
// into the output register, so the stream runs with no gap between words.
// after acceptance the job is registered in the emitter, and its first byte then moves into the output register.
// a stalled receiver holds the output register; the emitter and then the
// input side stop until out_ready returns.
// synchronous reset clears all record state, the byte offset and both
// valid flags.
`default_nettype none

module delta_of_delta_varint_encoder_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dod_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dod_pkg::out_word_t      out_data
);

  logic          accept;
  dod_pkg::job_t job;

  assign accept = in_valid && in_ready;

  dod_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .job     (job)
  );

  dod_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .job_in    (job),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/dod_checker.sv
// port-level checks for the delta-of-delta varint encoder, bound to the top level
// depends on dod_pkg
`default_nettype none

module dod_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire dod_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_nobyte_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.last && out_data.out_byte == 8'd0)
    else $error("word without a byte is not a final word");

  a_index_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.index_valid |-> out_data.last)
    else $error("index entry off the final word");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.index_valid |->
      out_data.index_offset == '0 && out_data.index_ts == '0 && out_data.index_price == '0)
    else $error("index fields set without index_valid");

  a_cont_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_valid && out_data.out_byte[7] |-> !out_data.last)
    else $error("continued varint byte marked last");

endmodule

bind delta_of_delta_varint_encoder_core dod_checker u_chk (.*);

`default_nettype wire
